[sv/sle_pkg.sv]
// Shared types and codes for the sorted list insert engine.
`default_nettype none

package sle_pkg;

   localparam int DEF_CAPACITY = 16;

   typedef logic [1:0]         mode_type;
   typedef logic [1:0]         status_type;
   typedef logic signed [31:0] word_type;
   typedef logic [3:0]         index_type;
   typedef logic [4:0]         count_type;

   localparam mode_type MODE_INSERT = 2'd0;
   localparam mode_type MODE_REMOVE = 2'd1;
   localparam mode_type MODE_CLEAR  = 2'd2;
   localparam mode_type MODE_READ   = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;
   localparam status_type ST_RANGE = 2'd3;

endpackage

`default_nettype wire

[sv/sorted_list_insert_engine_unit.sv]
// Sorted list engine: ascending store of signed words with insert/remove/clear/read.
//
// Usage:
//  - Request channel (req_valid/req_ready) carries one word: mode, value, index.
//    Modes: insert value at its sorted place, remove smallest, clear all,
//    read entry at index. Each request yields exactly one response word.
//  - Response channel (rsp_valid/rsp_ready) carries status, value_out and the
//    entry count after the operation.
//  - One request at a time: req_ready is high only while the sequencer is idle.
//    The entries live in a single-port-write / single-port-read RAM with a
//    registered read, and one shared signed comparator walks it.
//  - Clear, full insert, empty remove and bad index go straight to the response.
//    Read issues the RAM read, then captures it. Insert walks down from the top,
//    moving each entry not below the new value up one slot, then places it;
//    remove smallest reads each entry and writes it one slot down. Each step is a RAM read, then a compare/write.
//  - Response is held in registers until rsp_ready; a stalled receiver just
//    holds the engine in its output state, nothing is lost.
//  - Reset (synchronous, active high) empties the list; RAM contents are not
//    cleared, since only slots below the count are ever read.
`default_nettype none

module sorted_list_insert_engine_unit #(
   parameter int CAPACITY = sle_pkg::DEF_CAPACITY
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire  sle_pkg::mode_type  req_mode,
   input  wire  sle_pkg::word_type  req_value,
   input  wire  sle_pkg::index_type req_index,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output sle_pkg::status_type      rsp_status,
   output sle_pkg::word_type        rsp_value_out,
   output sle_pkg::count_type       rsp_count
);
   import sle_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);
   localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_INS_RD  = 4'd1;  // read entry below insert slot
   localparam logic [3:0] S_INS_CMP = 4'd2;  // compare, shift up or place
   localparam logic [3:0] S_INS_WR  = 4'd3;  // place at slot zero
   localparam logic [3:0] S_SH_RD   = 4'd4;  // remove: read slot pos
   localparam logic [3:0] S_SH_WR   = 4'd5;  // remove: capture or shift down
   localparam logic [3:0] S_RD_RD   = 4'd6;  // indexed read issue
   localparam logic [3:0] S_RD_CAP  = 4'd7;  // indexed read capture
   localparam logic [3:0] S_OUT     = 4'd8;  // response pending

   // entry RAM
   word_type mem [CAPACITY];
   word_type rdata_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   word_type wr_data;
   logic wr_en;

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;
   word_type value_ff, value_in;
   index_type index_ff, index_in;
   status_type status_ff, status_in;
   word_type vout_ff, vout_in;

   logic idx_bad;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = (state_ff == S_OUT);
   assign rsp_status    = status_ff;
   assign rsp_value_out = vout_ff;
   assign rsp_count     = count_type'(count_ff);

   // index past count, or past the store itself when it is small
   assign idx_bad = (int'(req_index) >= int'(count_ff)) || (int'(req_index) >= CAPACITY);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      value_in  = value_ff;
      index_in  = index_ff;
      status_in = status_ff;
      vout_in   = vout_ff;
      rd_addr   = AW'(pos_ff);
      wr_addr   = AW'(pos_ff);
      wr_data   = value_ff;
      wr_en     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in  = req_value;
               index_in  = req_index;
               status_in = ST_OK;
               vout_in   = '0;
               case (req_mode)
                  MODE_INSERT: begin
                     if (count_ff >= CNT_CAP) begin
                        status_in = ST_FULL;
                        state_in  = S_OUT;
                     end else begin
                        pos_in   = count_ff;
                        state_in = (count_ff == '0) ? S_INS_WR : S_INS_RD;
                     end
                  end
                  MODE_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_OUT;
                     end else begin
                        pos_in   = '0;
                        state_in = S_SH_RD;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                     state_in = S_OUT;
                  end
                  default: begin
                     if (idx_bad) begin
                        status_in = ST_RANGE;
                        state_in  = S_OUT;
                     end else begin
                        state_in = S_RD_RD;
                     end
                  end
               endcase
            end
         end
         S_INS_RD: begin
            rd_addr  = AW'(pos_ff - CNT_ONE);
            state_in = S_INS_CMP;
         end
         S_INS_CMP: begin
            wr_en = 1'b1;
            if (rdata_ff < value_ff) begin
               // slot found: new value sits above a smaller entry
               wr_data  = value_ff;
               count_in = count_ff + CNT_ONE;
               state_in = S_OUT;
            end else begin
               // equal or larger entry moves up one slot
               wr_data  = rdata_ff;
               pos_in   = pos_ff - CNT_ONE;
               state_in = (pos_ff == CNT_ONE) ? S_INS_WR : S_INS_RD;
            end
         end
         S_INS_WR: begin
            wr_en    = 1'b1;
            wr_data  = value_ff;
            count_in = count_ff + CNT_ONE;
            state_in = S_OUT;
         end
         S_SH_RD: begin
            rd_addr  = AW'(pos_ff);
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            if (pos_ff == '0) begin
               vout_in = rdata_ff;
            end else begin
               wr_en   = 1'b1;
               wr_addr = AW'(pos_ff - CNT_ONE);
               wr_data = rdata_ff;
            end
            if (pos_ff == count_ff - CNT_ONE) begin
               count_in = count_ff - CNT_ONE;
               state_in = S_OUT;
            end else begin
               pos_in   = pos_ff + CNT_ONE;
               state_in = S_SH_RD;
            end
         end
         S_RD_RD: begin
            rd_addr  = AW'(index_ff);
            state_in = S_RD_CAP;
         end
         S_RD_CAP: begin
            vout_in  = rdata_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff    <= pos_in;
      value_ff  <= value_in;
      index_ff  <= index_in;
      status_ff <= status_in;
      vout_ff   <= vout_in;
   end

endmodule

`default_nettype wire

[tb/tb_sorted_list_insert_engine_unit.sv]
// Self-checking testbench for the sorted list insert engine: directed table, then random words.
module tb_sorted_list_insert_engine_unit;
   import sle_pkg::*;

   localparam int CAP         = DEF_CAPACITY;
   localparam int ITEMS       = 1300;
   // Slowest word is a remove on a full store or an insert to slot zero of a nearly full one;
   // receiver stalls are short random runs, so this is several times the worst.
   localparam int QUIET_LIMIT = 3000;
   localparam int DRAIN_WAIT  = 40;
   localparam word_type W_MIN = 32'sh8000_0000;
   localparam word_type W_MAX = 32'sh7FFF_FFFF;

   // Value styles for random words.
   localparam int STYLE_ANY     = 0;
   localparam int STYLE_CLOSE   = 1;   // narrow band, lots of equal values
   localparam int STYLE_EXTREME = 2;

   typedef struct packed {
      status_type status;
      word_type   value_out;
      count_type  count;
   } outcome_type;

   typedef struct {
      mode_type    mode;
      word_type    value;
      index_type   index;
      logic        known;    // expected result typed in below
      outcome_type outc;
   } plan_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   mode_type   req_mode = MODE_CLEAR;
   word_type   req_value = '0;
   index_type  req_index = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   status_type rsp_status;
   word_type   rsp_value_out;
   count_type  rsp_count;

   // Typed-in expectation travels with the request word it belongs to.
   logic        req_known = 1'b0;
   outcome_type known_outcome = '0;

   // Shadow of the engine's store.
   word_type   shadow_words [CAP];
   int         shadow_count = 0;

   outcome_type pending_outcomes [$];
   int         errors = 0;
   int         quiet_cycles = 0;
   int         words_sent = 0;
   logic       calm = 1'b0;   // no idling on either side while set

   // Directed part: empty-store errors, extremes, equal values, index range.
   plan_row_type plan [21] = '{
      '{MODE_REMOVE, 32'sh1234_5678, 4'd0,  1'b1, '{ST_EMPTY, 32'sd0, 5'd0}},
      '{MODE_READ,   32'sd0,         4'd0,  1'b1, '{ST_RANGE, 32'sd0, 5'd0}},
      '{MODE_CLEAR,  32'shFFFF_FFFF, 4'd15, 1'b1, '{ST_OK,    32'sd0, 5'd0}},
      '{MODE_INSERT, W_MAX,          4'd0,  1'b1, '{ST_OK,    32'sd0, 5'd1}},
      '{MODE_INSERT, W_MIN,          4'd15, 1'b1, '{ST_OK,    32'sd0, 5'd2}},
      '{MODE_INSERT, 32'sd5,         4'd0,  1'b0, '0},
      '{MODE_INSERT, 32'sd5,         4'd0,  1'b0, '0},
      '{MODE_INSERT, -32'sd1,        4'd0,  1'b0, '0},
      '{MODE_INSERT, 32'sd0,         4'd0,  1'b0, '0},
      '{MODE_READ,   32'sd0,         4'd0,  1'b1, '{ST_OK,    W_MIN,  5'd6}},
      '{MODE_READ,   32'sd0,         4'd5,  1'b1, '{ST_OK,    W_MAX,  5'd6}},
      '{MODE_READ,   32'sd0,         4'd2,  1'b0, '0},
      '{MODE_READ,   32'sd0,         4'd6,  1'b1, '{ST_RANGE, 32'sd0, 5'd6}},
      '{MODE_READ,   W_MAX,          4'd15, 1'b1, '{ST_RANGE, 32'sd0, 5'd6}},
      '{MODE_REMOVE, 32'sd0,         4'd0,  1'b1, '{ST_OK,    W_MIN,  5'd5}},
      '{MODE_READ,   32'sd0,         4'd0,  1'b0, '0},
      '{MODE_CLEAR,  32'sd0,         4'd0,  1'b1, '{ST_OK,    32'sd0, 5'd0}},
      '{MODE_READ,   32'sd0,         4'd0,  1'b1, '{ST_RANGE, 32'sd0, 5'd0}},
      '{MODE_REMOVE, 32'sd0,         4'd0,  1'b1, '{ST_EMPTY, 32'sd0, 5'd0}},
      '{MODE_INSERT, -32'sd7,        4'd0,  1'b0, '0},
      '{MODE_READ,   32'sd0,         4'd0,  1'b1, '{ST_OK,    -32'sd7, 5'd1}}
   };

   sorted_list_insert_engine_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .req_index     (req_index),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_count     (rsp_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // One operation on the shadow store; returns the response word it implies.
   function automatic void sorted_store_step(input mode_type m, input word_type v,
                                             input index_type ix, output outcome_type o);
      int pos;
      int k;
      o = '{ST_OK, 32'sd0, 5'd0};
      case (m)
         MODE_INSERT: begin
            if (shadow_count >= CAP) begin
               o.status = ST_FULL;
            end else begin
               // new value lands ahead of any equal ones (signed order)
               pos = 0;
               while (pos < shadow_count && shadow_words[pos] < v) pos++;
               for (k = shadow_count; k > pos; k--) shadow_words[k] = shadow_words[k-1];
               shadow_words[pos] = v;
               shadow_count++;
            end
         end
         MODE_REMOVE: begin
            if (shadow_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.value_out = shadow_words[0];
               for (k = 1; k < shadow_count; k++) shadow_words[k-1] = shadow_words[k];
               shadow_count--;
            end
         end
         MODE_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
            if (int'(ix) >= shadow_count) o.status = ST_RANGE;
            else o.value_out = shadow_words[ix];
         end
      endcase
      o.count = count_type'(shadow_count);
   endfunction

   // Monitor: both channels sampled at the rising edge, before the engine's
   // own updates land. Response first: it always belongs to an older word.
   always @(posedge clock) begin
      outcome_type predicted;
      outcome_type wanted;
      outcome_type seen;
      logic        moved;
      moved = 1'b0;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         moved = 1'b1;
         seen  = '{rsp_status, rsp_value_out, rsp_count};
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected response: expected none, got status %0d value %0d count %0d",
                     $time, seen.status, seen.value_out, seen.count);
            errors++;
         end else begin
            wanted = pending_outcomes.pop_front();
            if (seen.status !== wanted.status) begin
               $display("%0t: status mismatch: expected %0d, got %0d",
                        $time, wanted.status, seen.status);
               errors++;
            end
            if (seen.value_out !== wanted.value_out) begin
               $display("%0t: value_out mismatch: expected %0d, got %0d",
                        $time, wanted.value_out, seen.value_out);
               errors++;
            end
            if (seen.count !== wanted.count) begin
               $display("%0t: count mismatch: expected %0d, got %0d",
                        $time, wanted.count, seen.count);
               errors++;
            end
         end
      end
      if (!reset && req_valid && req_ready === 1'b1) begin
         moved = 1'b1;
         // shadow always advances, even when the row carries its own answer
         sorted_store_step(req_mode, req_value, req_index, predicted);
         pending_outcomes.push_back(req_known ? known_outcome : predicted);
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
   end

   // Receiver: drops ready about a third of the time, never while calm.
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 34);
   end

   // Present one request word, hold it until taken, then maybe idle a bit.
   // Called at a rising edge; returns at one.
   task automatic offer_word(input mode_type m, input word_type v, input index_type ix,
                             input logic known, input outcome_type o);
      req_valid     <= 1'b1;
      req_mode      <= m;
      req_value     <= v;
      req_index     <= ix;
      req_known     <= known;
      known_outcome <= o;
      do @(posedge clock); while (req_ready !== 1'b1);
      words_sent++;
      if (!calm && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Sender goes quiet until every outstanding response word has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic word_type pick_value(input int style);
      case (style)
         STYLE_CLOSE: return word_type'($urandom_range(0, 8)) - 32'sd4;
         STYLE_EXTREME: begin
            case ($urandom_range(0, 6))
               0:       return W_MIN;
               1:       return W_MIN + 32'sd1;
               2:       return -32'sd1;
               3:       return 32'sd0;
               4:       return 32'sd1;
               5:       return W_MAX - 32'sd1;
               default: return W_MAX;
            endcase
         end
         default: return word_type'($urandom);
      endcase
   endfunction

   // Clear, overfill (full drops), read every slot, then drain past empty.
   task automatic fill_and_drain(input int style);
      int n;
      offer_word(MODE_CLEAR, pick_value(STYLE_ANY), index_type'($urandom), 1'b0, '0);
      for (n = 0; n < CAP + $urandom_range(1, 3); n++)
         offer_word(MODE_INSERT, pick_value(style), index_type'($urandom), 1'b0, '0);
      for (n = 0; n < CAP; n++)
         offer_word(MODE_READ, pick_value(STYLE_ANY), index_type'(n), 1'b0, '0);
      for (n = 0; n < CAP + $urandom_range(1, 2); n++)
         offer_word(MODE_REMOVE, pick_value(STYLE_ANY), index_type'($urandom), 1'b0, '0);
   endtask

   // Mixed traffic, insert-heavy so the store spends time near full.
   task automatic mixed_burst(input int style);
      int n;
      int pick;
      mode_type m;
      for (n = 0; n < 20; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)      m = MODE_INSERT;
         else if (pick < 65) m = MODE_REMOVE;
         else if (pick < 95) m = MODE_READ;
         else                m = MODE_CLEAR;
         offer_word(m, pick_value(style), index_type'($urandom_range(0, 15)), 1'b0, '0);
      end
   endtask

   initial begin
      bit paused;
      int i;
      paused = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < $size(plan); i++)
         offer_word(plan[i].mode, plan[i].value, plan[i].index, plan[i].known, plan[i].outc);
      drain_responses();
      fill_and_drain(STYLE_CLOSE);

      while (words_sent < ITEMS) begin
         calm = (words_sent >= 500 && words_sent < 800);
         if ($urandom_range(0, 99) < 25) fill_and_drain($urandom_range(0, 2));
         else mixed_burst($urandom_range(0, 2));
         if (!paused && words_sent >= 650) begin
            drain_responses();
            paused = 1'b1;
         end
      end
      calm = 1'b0;

      drain_responses();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: too long with no word moving on either channel.
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
   end

endmodule
